### src/ccext_pkg.sv
// Shared types and constants for the cycle counter extension block.
`default_nettype none

package ccext_pkg;

  // Fixed field widths.
  localparam int unsigned SampleW = 32;
  localparam int unsigned CountW  = 64;
  localparam int unsigned FreqW   = 32;
  localparam int unsigned MsW     = 32;
  localparam int unsigned UsConstW = 20;
  localparam int unsigned ProdW   = SampleW + UsConstW;

  // Conversion constants.
  localparam logic [UsConstW-1:0] US_PER_S   = 20'd1000000;
  localparam logic [FreqW-1:0]    US_PER_MS  = 32'd1000;
  localparam logic [FreqW-1:0]    FREQ_RESET = 32'd480000000;

  // Reciprocal division by 1000, taking 16 dividend bits per digit. The partial
  // dividend stays below 1000 * 2^16, where ceil(2^36 / 1000) gives exact quotients.
  localparam int unsigned MsDigitW = 16;
  localparam int unsigned MsRemW   = 10;
  localparam int unsigned MsNumW   = MsRemW + MsDigitW;
  localparam int unsigned MsRecipW = 27;
  localparam int unsigned MsProdW  = MsNumW + MsRecipW;
  localparam int unsigned MS_SHIFT = 36;
  localparam logic [MsRecipW-1:0] MS_RECIP = 27'd68719477;

  // Configuration register indexes.
  localparam logic CFG_FREQ = 1'b0;
  localparam logic CFG_EN   = 1'b1;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [CountW-1:0] dividend;
    logic [FreqW-1:0]  divisor;
  } div_req_t;

  // Status from the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### src/ccext_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none

module ccext_div
  import ccext_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire div_req_t          req_i,
  output div_stat_t              stat_o,
  output logic [CountW-1:0]      quotient_o,
  output logic [FreqW-1:0]       remainder_o
);

  localparam int unsigned CntW = $clog2(CountW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0] quo_q, quo_d;
  logic [FreqW-1:0]  rem_q, rem_d;
  logic [FreqW-1:0]  dvs_q, dvs_d;
  logic [FreqW:0]    shifted;
  logic [FreqW:0]    diff;
  logic              ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_q, quo_q[CountW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  // Step control.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[CountW-2:0], ge};
      rem_d = ge ? diff[FreqW-1:0] : shifted[FreqW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(CountW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

`default_nettype wire

### src/cycle_counter_extend_to_microseconds.sv
// Conversion path when enabled with a nonzero frequency: two 64-step passes through the
// shared restoring divider (cycles / f and fractional microseconds / f), three multiply
// steps and four reciprocal digits for the division by 1000. Disabled or zero-frequency
// samples go straight to the result. A new sample is taken only once the previous one has
// finished; the next input is taken while a finished result waits in the output register.
// Reset: accumulator and previous sample clear, frequency 480 MHz, block disabled.
`default_nettype none

module cycle_counter_extend_to_microseconds
  import ccext_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [FreqW-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [SampleW-1:0] counter_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CountW-1:0]       total_cycles_o,
  output logic [CountW-1:0]       time_us_o,
  output logic [MsW-1:0]          time_ms_o
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b0000000001,
    S_DIV_WHOLE  = 10'b0000000010,
    S_MUL_LO     = 10'b0000000100,
    S_MUL_HI     = 10'b0000001000,
    S_MUL_REST   = 10'b0000010000,
    S_FRAC_START = 10'b0000100000,
    S_DIV_FRAC   = 10'b0001000000,
    S_MS_MUL     = 10'b0010000000,
    S_MS_SUB     = 10'b0100000000,
    S_FIN        = 10'b1000000000
  } state_e;

  state_e              state_q, state_d;
  logic [FreqW-1:0]    freq_q;
  logic                en_q;
  logic [SampleW-1:0]  prev_q;
  logic [CountW-1:0]   acc_q;
  logic [SampleW-1:0]  elapsed;
  logic [CountW-1:0]   acc_sum;
  logic [CountW-1:0]   cyc_q;
  logic [CountW-1:0]   whole_q;
  logic [FreqW-1:0]    rest_q;
  logic [ProdW-1:0]    prod_q;
  logic [CountW-1:0]   us_q;
  logic [MsW-1:0]      ms_q;
  logic [1:0]          ms_cnt_q;
  logic [MsRemW-1:0]   ms_rem_q;
  logic [MsDigitW-1:0] ms_qd_q;
  logic [MsDigitW-1:0] ms_digit;
  logic [MsNumW-1:0]   ms_num;
  logic [MsProdW-1:0]  ms_prod;
  logic [MsNumW-1:0]   ms_back;
  logic [MsNumW-1:0]   ms_left;
  logic                out_valid_q;
  logic [CountW-1:0]   out_cyc_q;
  logic [CountW-1:0]   out_us_q;
  logic [MsW-1:0]      out_ms_q;
  logic                in_acc;
  logic                load_out;
  logic                run;
  logic [SampleW-1:0]  mul_a;
  logic [ProdW-1:0]    mul_p;
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [CountW-1:0]   div_quo;
  logic [FreqW-1:0]    div_rem;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign run        = en_q && (freq_q != '0);

  // The counter step wraps at 32 bits before it joins the 64-bit count.
  assign elapsed    = counter_sample_i - prev_q;
  assign acc_sum    = acc_q + CountW'(elapsed);

  // Shared divider.
  ccext_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Shared 32 x 20 multiplier by one million.
  always_comb begin
    unique case (state_q)
      S_MUL_HI:   mul_a = whole_q[CountW-1:SampleW];
      S_MUL_REST: mul_a = rest_q;
      default:    mul_a = whole_q[SampleW-1:0];
    endcase
  end
  assign mul_p = ProdW'(mul_a) * ProdW'(US_PER_S);

  // Division by 1000, one 16-bit digit of the microseconds at a time, top digit first.
  assign ms_digit = us_q[{~ms_cnt_q, 4'b0000} +: MsDigitW];
  assign ms_num   = {ms_rem_q, ms_digit};
  assign ms_prod  = MsProdW'(ms_num) * MsProdW'(MS_RECIP);
  assign ms_back  = MsNumW'(ms_qd_q) * MsNumW'(US_PER_MS);
  assign ms_left  = ms_num - ms_back;

  // Sequencer and divider requests.
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = acc_sum;
    div_req.divisor  = freq_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (run) begin
            div_req.start = 1'b1;
            state_d       = S_DIV_WHOLE;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_DIV_WHOLE: begin
        if (div_stat.done) state_d = S_MUL_LO;
      end
      S_MUL_LO:   state_d = S_MUL_HI;
      S_MUL_HI:   state_d = S_MUL_REST;
      S_MUL_REST: state_d = S_FRAC_START;
      S_FRAC_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = CountW'(prod_q);
        state_d          = S_DIV_FRAC;
      end
      S_DIV_FRAC: begin
        if (div_stat.done) state_d = S_MS_MUL;
      end
      S_MS_MUL: state_d = S_MS_SUB;
      S_MS_SUB: begin
        if (ms_cnt_q == '1) begin
          state_d = S_FIN;
        end else begin
          state_d = S_MS_MUL;
        end
      end
      S_FIN: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and the extended counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      freq_q      <= FREQ_RESET;
      en_q        <= 1'b0;
      prev_q      <= '0;
      acc_q       <= '0;
      ms_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FREQ: freq_q <= cfg_wdata_i;
          CFG_EN:   en_q   <= cfg_wdata_i[0];
          default:  ;
        endcase
      end
      if (in_acc && en_q) begin
        prev_q <= counter_sample_i;
        acc_q  <= acc_sum;
      end
      // The digit count wraps back to zero after the last digit.
      if (state_q == S_MS_SUB) begin
        ms_cnt_q <= ms_cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: whole seconds times one million, plus the fractional part, then ms.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cyc_q    <= en_q ? acc_sum : '0;
        us_q     <= '0;
        ms_q     <= '0;
        ms_rem_q <= '0;
      end
      S_DIV_WHOLE: begin
        whole_q <= div_quo;
        rest_q  <= div_rem;
      end
      S_MUL_LO: prod_q <= mul_p;
      S_MUL_HI: begin
        us_q   <= CountW'(prod_q);
        prod_q <= mul_p;
      end
      S_MUL_REST: begin
        us_q   <= us_q + {prod_q[SampleW-1:0], {SampleW{1'b0}}};
        prod_q <= mul_p;
      end
      S_DIV_FRAC: begin
        if (div_stat.done) us_q <= us_q + div_quo;
      end
      S_MS_MUL: ms_qd_q <= ms_prod[MS_SHIFT +: MsDigitW];
      S_MS_SUB: begin
        ms_rem_q <= ms_left[MsRemW-1:0];
        ms_q     <= {ms_q[MsW-MsDigitW-1:0], ms_qd_q};
      end
      default: ;
    endcase
    if (load_out) begin
      out_cyc_q <= cyc_q;
      out_us_q  <= us_q;
      out_ms_q  <= ms_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign total_cycles_o = out_cyc_q;
  assign time_us_o      = out_us_q;
  assign time_ms_o      = out_ms_q;

  // The divider only finishes while the sequencer waits on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV_WHOLE || state_q == S_DIV_FRAC))
    else $error("divider finished outside a divide state");

  // No new sample is taken while the divider is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // An enabled sample with a valid frequency starts the whole-seconds division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && run) |=> (state_q == S_DIV_WHOLE && div_stat.busy))
    else $error("division did not start after input transaction");

  // A result is only loaded when the output register is free or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

### verif/cycle_counter_extend_to_microseconds_test.sv
// Self-checking testbench for the cycle counter extension and time conversion block.
`timescale 1ns / 1ps

module cycle_counter_extend_to_microseconds_test
  import ccext_pkg::*;
();

  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned SampleTarget = 1800;
  localparam int unsigned TailCycles   = 250;

  // One converted time reading as the block returns it.
  typedef struct packed {
    logic [CountW-1:0] cycles;
    logic [CountW-1:0] us;
    logic [MsW-1:0]    ms;
  } time_reading_t;

  // Mirrors the register and counter state and queues the readings to come.
  class timebase_scoreboard;
    logic [FreqW-1:0]   freq_hz;
    logic               enabled;
    logic [SampleW-1:0] last_sample;
    logic [CountW-1:0]  cycle_total;
    time_reading_t      pending_readings[$];
    int unsigned        errors;

    function new();
      freq_hz     = FREQ_RESET;
      enabled     = 1'b0;
      last_sample = '0;
      cycle_total = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic idx, logic [FreqW-1:0] data);
      if (idx == CFG_FREQ) begin
        freq_hz = data;
      end else begin
        enabled = data[0];
      end
    endfunction

    // Extends an accepted sample and converts the running count to time; a disabled block gives zeros.
    function void note_sample(logic [SampleW-1:0] sample);
      time_reading_t    r;
      logic [CountW-1:0] f;
      logic [CountW-1:0] whole;
      logic [CountW-1:0] rest;
      r = '0;
      if (enabled) begin
        cycle_total = cycle_total + {32'b0, sample - last_sample};
        last_sample = sample;
        r.cycles = cycle_total;
        if (freq_hz != 0) begin
          f     = {32'b0, freq_hz};
          whole = cycle_total / f;
          rest  = cycle_total % f;
          // The whole-seconds product wraps at 64 bits, just like the block.
          r.us  = whole * 64'd1000000 + (rest * 64'd1000000) / f;
          r.ms  = MsW'(r.us / 64'd1000);
        end
      end
      pending_readings.push_back(r);
    endfunction

    function void check_result(logic [CountW-1:0] cycles, logic [CountW-1:0] us,
                               logic [MsW-1:0] ms);
      time_reading_t exp_r;
      if (pending_readings.size() == 0) begin
        $error("unexpected result: total_cycles %0d time_us %0d time_ms %0d",
               cycles, us, ms);
        errors++;
        return;
      end
      exp_r = pending_readings.pop_front();
      if (cycles !== exp_r.cycles) begin
        $error("total_cycles: expected %0d, got %0d", exp_r.cycles, cycles);
        errors++;
      end
      if (us !== exp_r.us) begin
        $error("time_us: expected %0d, got %0d", exp_r.us, us);
        errors++;
      end
      if (ms !== exp_r.ms) begin
        $error("time_ms: expected %0d, got %0d", exp_r.ms, ms);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_readings.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = CFG_FREQ;
  logic [FreqW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] counter_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CountW-1:0]  total_cycles_o;
  logic [CountW-1:0]  time_us_o;
  logic [MsW-1:0]     time_ms_o;

  timebase_scoreboard sb;
  bit                 tx_quiet = 1'b0;
  bit                 rx_quiet = 1'b0;
  int unsigned        rx_wait = 0;
  int unsigned        cycles_run = 0;
  int unsigned        samples_sent = 0;
  logic [SampleW-1:0] counter_now = '0;

  cycle_counter_extend_to_microseconds dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .counter_sample_i (counter_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .total_cycles_o   (total_cycles_o),
    .time_us_o        (time_us_o),
    .time_ms_o        (time_ms_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check each transaction, then stall ready for a random while unless rx_quiet is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(total_cycles_o, time_us_o, time_ms_o);
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 12);
        out_ready_i <= (rx_wait == 0);
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ready_i <= (rx_wait == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Sends one sample after a random gap (none when tx_quiet is set) and waits for its transaction.
  task automatic send_sample(input logic [SampleW-1:0] sample);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    counter_sample_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(sample);
    samples_sent++;
  endtask

  // Drops valid and waits until every expected result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input logic idx, input logic [FreqW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Picks a frequency, biased toward the extremes and common values.
  function automatic logic [FreqW-1:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return FREQ_RESET;
      4:       return $urandom_range(1, 1000);
      5:       return $urandom_range(1000, 10_000_000);
      default: return $urandom;
    endcase
  endfunction

  // Advances the modeled hardware counter by a random step.
  function automatic logic [SampleW-1:0] next_counter(logic [SampleW-1:0] cur);
    case ($urandom_range(0, 9))
      0, 1, 2: return cur + $urandom_range(0, 2000);
      3, 4:    return cur + $urandom;
      5:       return cur + $urandom_range(0, 1 << 20);
      6:       return cur - $urandom_range(1, 100);
      7:       return cur + 32'hFFFF_FFFF - $urandom_range(0, 3);
      8:       return cur;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned phase_len;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: disabled after reset, the state must not move.
    send_sample(32'h1234_5678);
    send_sample(32'hFFFF_FFFF);
    drain_results();
    write_reg(CFG_EN, 32'h0000_0001);

    // Enabled at the reset frequency, including a counter wrap.
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0005);
    send_sample(32'h8000_0000);
    drain_results();

    // Zero frequency: cycles accumulate, times stay zero.
    write_reg(CFG_FREQ, 32'h0000_0000);
    send_sample(32'hC000_0000);
    send_sample(32'h0000_0001);
    drain_results();

    // Frequency extremes.
    write_reg(CFG_FREQ, 32'h0000_0001);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    drain_results();
    write_reg(CFG_FREQ, 32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFE);
    drain_results();
    write_reg(CFG_FREQ, 32'd1_000_000);
    send_sample(32'h0001_0000);
    send_sample(32'hABCD_EF01);
    drain_results();

    // Disable with upper data bits set, then enable again without clearing.
    write_reg(CFG_EN, 32'hFFFF_FFFE);
    send_sample(32'hAAAA_AAAA);
    drain_results();
    write_reg(CFG_EN, 32'hFFFF_FFFF);
    send_sample(32'h5555_5555);
    drain_results();
    write_reg(CFG_FREQ, 32'd1000);
    send_sample(32'h5555_5600);
    send_sample(32'h0000_0010);
    counter_now = 32'h0000_0010;
    drain_results();

    // Random phases, each with its own settings and idling style.
    while (samples_sent < SampleTarget) begin
      write_reg(CFG_FREQ, pick_freq());
      write_reg(CFG_EN, {31'($urandom_range(0, 32'h7FFF_FFFF)),
                         ($urandom_range(0, 7) != 0)});
      tx_quiet  = ($urandom_range(0, 3) == 0);
      rx_quiet  = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 180);
      repeat (phase_len) begin
        counter_now = next_counter(counter_now);
        send_sample(counter_now);
        if ($urandom_range(0, 49) == 0) begin
          drain_results();
        end
      end
      drain_results();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Let any stray result show up before the verdict.
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
